### src/iprc_pkg.sv
// Shared types, field widths and helpers for the IPv4 rule classifier.
// Used by the classifier cell and the top level; no dependencies.

package iprc_pkg;

    // field widths fixed by the stream format
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 16;
    localparam int SLOT_W = 10;

    // default table depth
    localparam int RULE_DEPTH_DEFAULT = 1024;

    // beat kinds carried in tuser
    typedef enum logic [0:0] {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    // one beat travelling down the cell chain
    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   rule_slot;
        logic [ADDR_W-1:0]   src_addr;
        logic [ADDR_W-1:0]   src_mask;
        logic [PORT_W-1:0]   src_port;
        logic [ADDR_W-1:0]   dst_addr;
        logic [ADDR_W-1:0]   dst_mask;
        logic [PORT_W-1:0]   dst_port;
        logic                hit;
        logic [SLOT_W-1:0]   hit_slot;
    } item_t;

    // prefix length to address mask, lengths above the address width saturate
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        mask = '0;
        if (len == '0) begin
            mask = '0;
        end else if (len >= LEN_W'(ADDR_W)) begin
            mask = '1;
        end else begin
            mask = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - len);
        end
        return mask;
    endfunction

endpackage

### src/iprc_cell.sv
// One rule slot of the classifier chain: holds a rule, compares each passing beat.
// Depends on iprc_pkg for the beat struct and widths.

module iprc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  iprc_pkg::item_t in_item,
    output logic            out_valid,
    output iprc_pkg::item_t out_item
);
    import iprc_pkg::*;

    localparam logic [31:0] CELL_IDX_W = 32'(CELL_IDX);

    logic              rule_valid_reg;
    logic [ADDR_W-1:0] rule_src_prefix_reg;
    logic [ADDR_W-1:0] rule_src_mask_reg;
    logic [PORT_W-1:0] rule_src_port_reg;
    logic [ADDR_W-1:0] rule_dst_prefix_reg;
    logic [ADDR_W-1:0] rule_dst_mask_reg;
    logic [PORT_W-1:0] rule_dst_port_reg;

    logic              out_valid_reg;
    item_t             out_item_reg;
    item_t             item_next;

    logic              load_here;
    logic              src_hit;
    logic              dst_hit;

    // load beat addressed to this slot
    assign load_here = in_valid && (in_item.op == OP_LOAD) &&
                       (32'(in_item.rule_slot) == CELL_IDX_W);

    // side tests against the stored rule
    assign src_hit = ((in_item.src_addr & rule_src_mask_reg) == rule_src_prefix_reg) &&
                     ((rule_src_port_reg == '0) || (rule_src_port_reg == in_item.src_port));
    assign dst_hit = ((in_item.dst_addr & rule_dst_mask_reg) == rule_dst_prefix_reg) &&
                     ((rule_dst_port_reg == '0) || (rule_dst_port_reg == in_item.dst_port));

    // first match wins: only mark a classify beat that has no hit yet
    always_comb begin
        item_next = in_item;
        if (in_item.op == OP_CLASSIFY && !in_item.hit && rule_valid_reg &&
            src_hit && dst_hit) begin
            item_next.hit      = 1'b1;
            item_next.hit_slot = SLOT_W'(CELL_IDX);
        end
    end

    // rule storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_valid_reg <= 1'b0;
        end else if (advance && load_here) begin
            rule_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load_here) begin
            rule_src_prefix_reg <= in_item.src_addr;
            rule_src_mask_reg   <= in_item.src_mask;
            rule_src_port_reg   <= in_item.src_port;
            rule_dst_prefix_reg <= in_item.dst_addr;
            rule_dst_mask_reg   <= in_item.dst_mask;
            rule_dst_port_reg   <= in_item.dst_port;
        end
    end

    // hand the beat to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### src/ipv4_prefix_port_rule_classifier.sv
// IPv4 first-match rule classifier: a chain of RULE_DEPTH rule cells.
// An accepted classify beat passes through every rule cell, slot 0 first, and then the output register.
// Throughput: one beat per cycle, loads and classifies alike; a beat moves one cell a cycle.
// The whole chain holds while a result waits at the output register.
// Reset clears every cell's valid bit and the chain at once; no clearing sweep.
// Depends on iprc_pkg and iprc_cell.

module ipv4_prefix_port_rule_classifier #(
    parameter int RULE_DEPTH = iprc_pkg::RULE_DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    // rule_slot[9:0], src_addr[41:10], src_len[47:42], src_port[63:48],
    // dst_addr[95:64], dst_len[101:96], dst_port[117:102], zero pad[119:118]
    input  logic [119:0] s_tdata,
    // op[0]
    input  logic [0:0]   s_tuser,
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // matched[0], first_slot[10:1], zero pad[15:11]
    output logic [15:0]  m_tdata
);
    import iprc_pkg::*;

    logic              chain_valid [RULE_DEPTH+1];
    item_t             chain_item  [RULE_DEPTH+1];
    item_t             in_item;
    logic              advance;

    logic              out_valid_reg;
    logic              out_matched_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              tail_classify;

    // the chain moves whenever the output register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // unpack the input beat, lengths become masks here once
    always_comb begin
        in_item           = '0;
        in_item.op        = op_t'(s_tuser[0]);
        in_item.rule_slot = s_tdata[9:0];
        in_item.src_addr  = s_tdata[41:10];
        in_item.src_mask  = prefix_mask(s_tdata[47:42]);
        in_item.src_port  = s_tdata[63:48];
        in_item.dst_addr  = s_tdata[95:64];
        in_item.dst_mask  = prefix_mask(s_tdata[101:96]);
        in_item.dst_port  = s_tdata[117:102];
        in_item.hit       = 1'b0;
        in_item.hit_slot  = '0;
    end

    assign chain_valid[0] = s_tvalid;
    assign chain_item[0]  = in_item;

    // rule cells, slot 0 first
    for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
        iprc_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    // load beats end at the tail, classify beats become results
    assign tail_classify = chain_valid[RULE_DEPTH] &&
                           (chain_item[RULE_DEPTH].op == OP_CLASSIFY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= tail_classify;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_matched_reg <= chain_item[RULE_DEPTH].hit;
            out_slot_reg    <= chain_item[RULE_DEPTH].hit_slot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_slot_reg, out_matched_reg};

    // a miss reports slot zero
    a_miss_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[10:1] == '0))
        else $error("miss result with nonzero slot");

    // a hit names a slot that exists
    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (32'(m_tdata[10:1]) < 32'(RULE_DEPTH)))
        else $error("hit slot beyond table depth");

    // a classify beat leaving the chain always shows up at the output
    a_tail_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tail_classify) |=> m_tvalid)
        else $error("classify beat lost at chain tail");

    // a load beat leaving the chain never produces a result
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && chain_valid[RULE_DEPTH] && !tail_classify) |=> !m_tvalid)
        else $error("load beat produced a result");

endmodule

### tb/sv/ipv4_prefix_port_rule_classifier_tb.sv
// Self-checking testbench for the IPv4 first-match rule classifier.
// Streams rule loads and packet lookups through the block and checks every
// result beat against an internal rule table model or a hand-written outcome. Depends on iprc_pkg.

module ipv4_prefix_port_rule_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iprc_pkg::*;

    localparam int DEPTH       = RULE_DEPTH_DEFAULT;
    localparam int RAND_ITEMS  = 1500;
    localparam int NUM_DIR     = 24;
    localparam int HOLD_CYCLES = 8000;
    localparam int MAX_CYCLES  = 200000;
    localparam bit PREDICT     = 1'b0;
    localparam bit TYPED       = 1'b1;

    // one input beat, unpacked into its fields
    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] src_addr;
        logic [LEN_W-1:0]  src_len;
        logic [PORT_W-1:0] src_port;
        logic [ADDR_W-1:0] dst_addr;
        logic [LEN_W-1:0]  dst_len;
        logic [PORT_W-1:0] dst_port;
    } rule_beat_t;

    // lookup outcome
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } verdict_t;

    // directed stimulus row, with an optional hand-written outcome
    typedef struct packed {
        rule_beat_t beat;
        logic       typed;
        verdict_t   want;
    } dir_row_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [119:0]  s_tdata;
    logic [0:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [15:0]   m_tdata;

    // shadow copy of the rule table
    logic [ADDR_W-1:0] tbl_src_pfx  [DEPTH];
    logic [LEN_W-1:0]  tbl_src_len  [DEPTH];
    logic [PORT_W-1:0] tbl_src_port [DEPTH];
    logic [ADDR_W-1:0] tbl_dst_pfx  [DEPTH];
    logic [LEN_W-1:0]  tbl_dst_len  [DEPTH];
    logic [PORT_W-1:0] tbl_dst_port [DEPTH];
    logic              tbl_valid    [DEPTH];
    logic [SLOT_W-1:0] loaded_slots [$];

    verdict_t verdict_q [$];
    dir_row_t dir_tab [NUM_DIR];

    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int tx_idle_pct = 21;
    int rx_idle_pct = 81;
    bit hold_req    = 1'b0;

    ipv4_prefix_port_rule_classifier #(
        .RULE_DEPTH (DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // address mask for a prefix length, saturating above 32
    function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
        if (len == '0) begin
            return '0;
        end
        if (len >= LEN_W'(ADDR_W)) begin
            return '1;
        end
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

    // first valid rule whose both sides accept the packet
    function automatic verdict_t classify_packet(input rule_beat_t b);
        verdict_t v;
        bit       src_ok;
        bit       dst_ok;
        v = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i]) begin
                src_ok = ((b.src_addr & net_mask(tbl_src_len[i])) == tbl_src_pfx[i]) &&
                         (tbl_src_port[i] == '0 || tbl_src_port[i] == b.src_port);
                dst_ok = ((b.dst_addr & net_mask(tbl_dst_len[i])) == tbl_dst_pfx[i]) &&
                         (tbl_dst_port[i] == '0 || tbl_dst_port[i] == b.dst_port);
                if (src_ok && dst_ok) begin
                    v.hit  = 1'b1;
                    v.slot = SLOT_W'(i);
                    return v;
                end
            end
        end
        return v;
    endfunction

    // update the table or queue the expected lookup outcome
    function automatic void apply_beat(input rule_beat_t b, input bit typed,
                                       input verdict_t want);
        if (b.op == OP_LOAD) begin
            if (!tbl_valid[b.slot]) begin
                loaded_slots.push_back(b.slot);
            end
            tbl_src_pfx[b.slot]  = b.src_addr;
            tbl_src_len[b.slot]  = b.src_len;
            tbl_src_port[b.slot] = b.src_port;
            tbl_dst_pfx[b.slot]  = b.dst_addr;
            tbl_dst_len[b.slot]  = b.dst_len;
            tbl_dst_port[b.slot] = b.dst_port;
            tbl_valid[b.slot]    = 1'b1;
        end else begin
            verdict_q.push_back(typed ? want : classify_packet(b));
        end
    endfunction

    // random rule loads, lookups aimed at loaded rules, and plain noise
    function automatic rule_beat_t random_beat();
        rule_beat_t        b;
        logic [SLOT_W-1:0] pick;
        logic [ADDR_W-1:0] m;
        int                roll;
        b.slot     = SLOT_W'($urandom);
        b.src_addr = $urandom;
        b.src_len  = LEN_W'($urandom);
        b.src_port = PORT_W'($urandom);
        b.dst_addr = $urandom;
        b.dst_len  = LEN_W'($urandom);
        b.dst_port = PORT_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            b.op = OP_LOAD;
            // low slots get reloaded often and compete for first match
            if ($urandom_range(0, 1) == 0) begin
                b.slot = SLOT_W'($urandom_range(0, 31));
            end
            b.src_len = ($urandom_range(0, 99) < 15) ? LEN_W'($urandom_range(33, 63))
                                                     : LEN_W'($urandom_range(0, 32));
            b.dst_len = ($urandom_range(0, 99) < 15) ? LEN_W'($urandom_range(33, 63))
                                                     : LEN_W'($urandom_range(0, 32));
            // mostly clean prefixes, a few with stray low bits
            if ($urandom_range(0, 99) < 85) begin
                b.src_addr &= net_mask(b.src_len);
            end
            if ($urandom_range(0, 99) < 85) begin
                b.dst_addr &= net_mask(b.dst_len);
            end
            if ($urandom_range(0, 9) < 4) begin
                b.src_port = '0;
            end
            if ($urandom_range(0, 9) < 4) begin
                b.dst_port = '0;
            end
        end else begin
            b.op = OP_CLASSIFY;
            if (roll < 80 && loaded_slots.size() > 0) begin
                // build a packet that a loaded rule accepts
                pick = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
                m = net_mask(tbl_src_len[pick]);
                b.src_addr = (tbl_src_pfx[pick] & m) | (b.src_addr & ~m);
                m = net_mask(tbl_dst_len[pick]);
                b.dst_addr = (tbl_dst_pfx[pick] & m) | (b.dst_addr & ~m);
                if (tbl_src_port[pick] != '0) begin
                    b.src_port = tbl_src_port[pick];
                end
                if (tbl_dst_port[pick] != '0) begin
                    b.dst_port = tbl_dst_port[pick];
                end
                // near miss: one bit off
                if ($urandom_range(0, 99) < 20) begin
                    case ($urandom_range(0, 3))
                        0: b.src_addr ^= ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
                        1: b.src_port ^= PORT_W'(1) << $urandom_range(0, PORT_W - 1);
                        2: b.dst_addr ^= ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
                        default: b.dst_port ^= PORT_W'(1) << $urandom_range(0, PORT_W - 1);
                    endcase
                end
            end
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_cnt, what, want, got);
        err_cnt++;
    endtask

    // offer one beat and hold it until accepted
    task automatic push_beat(input rule_beat_t b, input bit typed, input verdict_t want);
        s_tvalid <= 1'b1;
        s_tuser  <= b.op;
        s_tdata  <= {2'b00, b.dst_port, b.dst_len, b.dst_addr,
                     b.src_port, b.src_len, b.src_addr, b.slot};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        apply_beat(b, typed, want);
    endtask

    // random gap between beats
    task automatic sender_gap();
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                @(posedge aclk);
            end
        end
    endtask

    // result side backpressure, with one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // check each result beat against the oldest expectation
    always @(posedge aclk) begin : watch_results
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected result beat, matched", 0, int'(m_tdata[0]));
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.hit) begin
                    report_mismatch("matched", int'(want.hit), int'(m_tdata[0]));
                end
                if (m_tdata[10:1] !== want.slot) begin
                    report_mismatch("first_slot", int'(want.slot), int'(m_tdata[10:1]));
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // main sequence
    initial begin
        rule_beat_t b;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOAD;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
        end

        // directed rows: catch-all, exact /32, saturated lengths,
        // unaligned prefix, one-bit prefix, reload, alternating bit patterns
        dir_tab = '{
            '{'{OP_CLASSIFY, 10'd1023, 32'hFFFF_FFFF, 6'd63, 16'hFFFF,
                32'hFFFF_FFFF, 6'd63, 16'hFFFF}, TYPED, '{1'b0, 10'd0}},
            '{'{OP_LOAD, 10'd1023, 32'h0, 6'd0, 16'h0, 32'h0, 6'd0, 16'h0},
                PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd0, 32'h0, 6'd0, 16'h0, 32'h0, 6'd0, 16'h0},
                TYPED, '{1'b1, 10'd1023}},
            '{'{OP_CLASSIFY, 10'd1023, 32'hFFFF_FFFF, 6'd63, 16'hFFFF,
                32'hFFFF_FFFF, 6'd63, 16'hFFFF}, TYPED, '{1'b1, 10'd1023}},
            '{'{OP_LOAD, 10'd0, 32'hC0A8_0001, 6'd32, 16'hFFFF,
                32'h0A00_0000, 6'd8, 16'd80}, PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd0, 32'hC0A8_0001, 6'd0, 16'hFFFF,
                32'h0A12_3456, 6'd0, 16'd80}, TYPED, '{1'b1, 10'd0}},
            '{'{OP_CLASSIFY, 10'd0, 32'hC0A8_0001, 6'd0, 16'hFFFF,
                32'h0A12_3456, 6'd0, 16'd81}, TYPED, '{1'b1, 10'd1023}},
            '{'{OP_CLASSIFY, 10'd0, 32'hC0A8_0002, 6'd0, 16'hFFFF,
                32'h0A12_3456, 6'd0, 16'd80}, TYPED, '{1'b1, 10'd1023}},
            '{'{OP_LOAD, 10'd5, 32'h0102_0304, 6'd40, 16'h0,
                32'hFFFF_FFFF, 6'd33, 16'hFFFF}, PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd0, 32'h0102_0304, 6'd0, 16'd1234,
                32'hFFFF_FFFF, 6'd0, 16'hFFFF}, TYPED, '{1'b1, 10'd5}},
            '{'{OP_CLASSIFY, 10'd0, 32'h0102_0305, 6'd0, 16'd1234,
                32'hFFFF_FFFF, 6'd0, 16'hFFFF}, TYPED, '{1'b1, 10'd1023}},
            '{'{OP_LOAD, 10'd3, 32'h0A00_0001, 6'd8, 16'h0, 32'h0, 6'd0, 16'h0},
                PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd0, 32'h0A00_0001, 6'd0, 16'h0, 32'h0, 6'd0, 16'h0},
                TYPED, '{1'b1, 10'd1023}},
            '{'{OP_LOAD, 10'd2, 32'h8000_0000, 6'd1, 16'h8000, 32'h0, 6'd0, 16'h0},
                PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd0, 32'h8000_0000, 6'd0, 16'h8000,
                32'h1234_5678, 6'd0, 16'd7}, TYPED, '{1'b1, 10'd2}},
            '{'{OP_CLASSIFY, 10'd0, 32'hFFFF_FFFF, 6'd0, 16'h8000, 32'h0, 6'd0, 16'h0},
                TYPED, '{1'b1, 10'd2}},
            '{'{OP_CLASSIFY, 10'd0, 32'h7FFF_FFFF, 6'd0, 16'h8000, 32'h0, 6'd0, 16'h0},
                TYPED, '{1'b1, 10'd1023}},
            '{'{OP_LOAD, 10'd1023, 32'hFFFF_FFFF, 6'd32, 16'd1,
                32'hFFFF_FFFF, 6'd32, 16'd1}, PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd0, 32'h0, 6'd0, 16'h0, 32'h0, 6'd0, 16'h0},
                TYPED, '{1'b0, 10'd0}},
            '{'{OP_CLASSIFY, 10'd0, 32'hFFFF_FFFF, 6'd0, 16'd1,
                32'hFFFF_FFFF, 6'd0, 16'd1}, TYPED, '{1'b1, 10'd1023}},
            '{'{OP_LOAD, 10'd512, 32'h0, 6'd0, 16'h0, 32'h0A00_0000, 6'd8, 16'h0},
                PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd0, 32'h0102_0304, 6'd0, 16'h0,
                32'h0A01_0101, 6'd0, 16'd80}, PREDICT, '0},
            '{'{OP_LOAD, 10'd341, 32'hAAAA_0000, 6'd16, 16'h5555,
                32'h5555_0000, 6'd16, 16'hAAAA}, PREDICT, '0},
            '{'{OP_CLASSIFY, 10'd682, 32'hAAAA_1234, 6'd21, 16'h5555,
                32'h5555_ABCD, 6'd42, 16'hAAAA}, PREDICT, '0}
        };

        // reset
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        for (int i = 0; i < NUM_DIR; i++) begin
            if (i > 0) begin
                sender_gap();
            end
            push_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
        end

        // pause until every lookup so far has come back
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) begin
            @(posedge aclk);
        end

        // random part, with one long result-side hold-off at its start
        hold_req = 1'b1;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 3) begin
                tx_idle_pct = 81;
                rx_idle_pct = 21;
            end else if (i == 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i > 0) begin
                sender_gap();
            end
            b = random_beat();
            push_beat(b, PREDICT, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray beats through one full pipeline
        while (verdict_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DEPTH + 16) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
